@@ rtl/core/rapq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rapq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BUCKET_SIZE  = 32;
    localparam int BUCKET_COUNT = 32;

    // Field widths of the channels
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int END_W    = 11;
    localparam int ADDEND_W = 32;
    localparam int VALUE_W  = 64;

    localparam int COUNT_RESET = 1024;

    localparam int ELEM_AW = $clog2(MAX_ELEMENTS);
    localparam int BKT_AW  = $clog2(BUCKET_COUNT);
    localparam int BKT_CW  = $clog2(BUCKET_COUNT + 1);

    // Position width: covers the bucket grid plus one bucket, the end field
    // and the element count clamp.
    localparam int GRID_W = $clog2(BUCKET_COUNT * BUCKET_SIZE + BUCKET_SIZE + 1);
    localparam int POS_W0 = (GRID_W > END_W + 1) ? GRID_W : END_W + 1;
    localparam int MAXC_W = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W  = (POS_W0 > MAXC_W) ? POS_W0 : MAXC_W;

    // Clearing sweep after reset covers the larger of the two stores
    localparam int CLR_N = (MAX_ELEMENTS > BUCKET_COUNT) ? MAX_ELEMENTS : BUCKET_COUNT;
    localparam int CLR_W = $clog2(CLR_N);

    typedef enum logic
    {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed
    {
        logic                 elem_rd;
        logic [ELEM_AW-1:0]   elem_rd_addr;
        logic                 elem_wr;
        logic [ELEM_AW-1:0]   elem_wr_addr;
        logic [VALUE_W-1:0]   elem_wr_data;
        logic                 ofs_rd;
        logic [BKT_AW-1:0]    ofs_rd_addr;
        logic                 ofs_wr;
        logic [BKT_AW-1:0]    ofs_wr_addr;
        logic [VALUE_W-1:0]   ofs_wr_data;
    } mem_req_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0] elem_rd_data;
        logic [VALUE_W-1:0] ofs_rd_data;
    } mem_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/rapq_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rapq_cmd_if;
    import rapq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [INDEX_W-1:0]         first_index;
    logic [END_W-1:0]           end_index;
    logic signed [ADDEND_W-1:0] addend;

    modport source (output valid, func, first_index, end_index, addend, input ready);
    modport sink   (input valid, func, first_index, end_index, addend, output ready);
endinterface

interface rapq_res_if;
    import rapq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      index_error;

    modport source (output valid, value, index_error, input ready);
    modport sink   (input valid, value, index_error, output ready);
endinterface

interface rapq_cfg_if;
    import rapq_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rapq_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rapq_store
(
    input  wire logic               clk,
    input  wire rapq_pkg::mem_req_t req,
    output rapq_pkg::mem_rsp_t      rsp
);
    import rapq_pkg::*;

    logic [VALUE_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [VALUE_W-1:0] ofs_mem  [BUCKET_COUNT];
    logic [VALUE_W-1:0] elem_rd_reg;
    logic [VALUE_W-1:0] ofs_rd_reg;

    // element store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.elem_wr)
        begin
            elem_mem[req.elem_wr_addr] <= req.elem_wr_data;
        end
        if (req.elem_rd)
        begin
            elem_rd_reg <= elem_mem[req.elem_rd_addr];
        end
    end

    // bucket offset store
    always_ff @(posedge clk)
    begin
        if (req.ofs_wr)
        begin
            ofs_mem[req.ofs_wr_addr] <= req.ofs_wr_data;
        end
        if (req.ofs_rd)
        begin
            ofs_rd_reg <= ofs_mem[req.ofs_rd_addr];
        end
    end

    assign rsp.elem_rd_data = elem_rd_reg;
    assign rsp.ofs_rd_data  = ofs_rd_reg;

endmodule

`default_nettype wire

@@ rtl/core/rapq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rapq_ctrl
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rapq_pkg::POS_W-1:0] count,
    rapq_cmd_if.sink                        cmd,
    rapq_res_if.source                      res,
    output rapq_pkg::mem_req_t              req,
    input  wire rapq_pkg::mem_rsp_t         rsp
);
    import rapq_pkg::*;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ELEM,
        ST_RESULT
    } state_t;

    state_t               state_reg,     state_next;
    logic [CLR_W-1:0]     clr_reg,       clr_next;
    logic                 func_reg,      func_next;
    logic [POS_W-1:0]     lo_reg,        lo_next;
    logic [POS_W-1:0]     hi_reg,        hi_next;
    logic [VALUE_W-1:0]   addend_reg,    addend_next;
    logic [BKT_CW-1:0]    k_reg,         k_next;
    logic [POS_W-1:0]     bl_reg,        bl_next;
    logic [POS_W-1:0]     i_reg,         i_next;
    logic [POS_W-1:0]     e_reg,         e_next;
    logic                 err_reg,       err_next;
    logic                 ofs_zero_reg,  ofs_zero_next;
    logic                 ewb_reg,       ewb_next;
    logic [ELEM_AW-1:0]   ewb_addr_reg,  ewb_addr_next;
    logic                 owb_reg,       owb_next;
    logic [BKT_AW-1:0]    owb_addr_reg,  owb_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_err_reg,   out_err_next;

    logic [POS_W-1:0] br;
    logic [POS_W-1:0] cmd_lo;
    logic [POS_W-1:0] cmd_end;
    logic [POS_W-1:0] cmd_hi;
    logic             out_free;
    logic             scan_done;

    assign br       = bl_reg + POS_W'(BUCKET_SIZE);
    assign cmd_lo   = POS_W'(cmd.first_index);
    assign cmd_end  = POS_W'(cmd.end_index);
    assign cmd_hi   = (cmd_end > count) ? count : cmd_end;
    assign out_free = !out_valid_reg || res.ready;
    assign scan_done = (k_reg == BKT_CW'(BUCKET_COUNT))
                    || ((func_reg == FUNC_ADD) && (hi_reg <= bl_reg));

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.value       = out_value_reg;
    assign res.index_error = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        addend_next    = addend_reg;
        k_next         = k_reg;
        bl_next        = bl_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        err_next       = err_reg;
        ofs_zero_next  = ofs_zero_reg;
        ewb_next       = 1'b0;
        ewb_addr_next  = ewb_addr_reg;
        owb_next       = 1'b0;
        owb_addr_next  = owb_addr_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        req            = '0;

        // write-back stage: finish the read-modify-write issued last cycle
        req.elem_wr      = ewb_reg;
        req.elem_wr_addr = ewb_addr_reg;
        req.elem_wr_data = rsp.elem_rd_data + addend_reg;
        req.ofs_wr       = owb_reg;
        req.ofs_wr_addr  = owb_addr_reg;
        req.ofs_wr_data  = rsp.ofs_rd_data + addend_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.elem_wr      = ({1'b0, clr_reg} < (CLR_W + 1)'(MAX_ELEMENTS));
                req.elem_wr_addr = clr_reg[ELEM_AW-1:0];
                req.elem_wr_data = '0;
                req.ofs_wr       = ({1'b0, clr_reg} < (CLR_W + 1)'(BUCKET_COUNT));
                req.ofs_wr_addr  = clr_reg[BKT_AW-1:0];
                req.ofs_wr_data  = '0;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next     = cmd.func;
                    lo_next       = cmd_lo;
                    hi_next       = cmd_hi;
                    addend_next   = {{(VALUE_W - ADDEND_W){cmd.addend[ADDEND_W-1]}},
                                     cmd.addend};
                    k_next        = '0;
                    bl_next       = '0;
                    err_next      = 1'b0;
                    ofs_zero_next = 1'b0;
                    if (cmd.func == FUNC_ADD)
                    begin
                        // empty range: nothing to do
                        if (cmd_lo < cmd_hi)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (cmd_lo >= count)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (func_reg == FUNC_ADD)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // element lies beyond the bucket grid: offset reads as zero
                        req.elem_rd      = 1'b1;
                        req.elem_rd_addr = lo_reg[ELEM_AW-1:0];
                        ofs_zero_next    = 1'b1;
                        state_next       = ST_RESULT;
                    end
                end
                else if (func_reg == FUNC_QUERY)
                begin
                    if (lo_reg < br)
                    begin
                        req.elem_rd      = 1'b1;
                        req.elem_rd_addr = lo_reg[ELEM_AW-1:0];
                        req.ofs_rd       = 1'b1;
                        req.ofs_rd_addr  = k_reg[BKT_AW-1:0];
                        state_next       = ST_RESULT;
                    end
                    else
                    begin
                        k_next  = k_reg + BKT_CW'(1);
                        bl_next = br;
                    end
                end
                else if (br <= lo_reg)
                begin
                    k_next  = k_reg + BKT_CW'(1);
                    bl_next = br;
                end
                else if ((lo_reg <= bl_reg) && (br <= hi_reg))
                begin
                    // whole bucket covered: add onto its offset
                    req.ofs_rd      = 1'b1;
                    req.ofs_rd_addr = k_reg[BKT_AW-1:0];
                    owb_next        = 1'b1;
                    owb_addr_next   = k_reg[BKT_AW-1:0];
                    k_next          = k_reg + BKT_CW'(1);
                    bl_next         = br;
                end
                else
                begin
                    // partly covered: walk its covered elements
                    i_next     = (lo_reg > bl_reg) ? lo_reg : bl_reg;
                    e_next     = (hi_reg < br) ? hi_reg : br;
                    state_next = ST_ELEM;
                end
            end

            ST_ELEM:
            begin
                if (i_reg < e_reg)
                begin
                    req.elem_rd      = 1'b1;
                    req.elem_rd_addr = i_reg[ELEM_AW-1:0];
                    ewb_next         = 1'b1;
                    ewb_addr_next    = i_reg[ELEM_AW-1:0];
                    i_next           = i_reg + POS_W'(1);
                end
                else
                begin
                    k_next     = k_reg + BKT_CW'(1);
                    bl_next    = br;
                    state_next = ST_SCAN;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_reg;
                    if (err_reg)
                    begin
                        out_value_next = '0;
                    end
                    else if (ofs_zero_reg)
                    begin
                        out_value_next = rsp.elem_rd_data;
                    end
                    else
                    begin
                        out_value_next = rsp.elem_rd_data + rsp.ofs_rd_data;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ewb_reg       <= 1'b0;
            owb_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ewb_reg       <= ewb_next;
            owb_reg       <= owb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        addend_reg    <= addend_next;
        k_reg         <= k_next;
        bl_reg        <= bl_next;
        i_reg         <= i_next;
        e_reg         <= e_next;
        err_reg       <= err_next;
        ofs_zero_reg  <= ofs_zero_next;
        ewb_addr_reg  <= ewb_addr_next;
        owb_addr_reg  <= owb_addr_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    // a write-back never races a read of the same element
    a_elem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ewb_reg && req.elem_rd) |-> (req.elem_rd_addr != ewb_addr_reg))
        else $error("element read overlaps pending write-back");

    // a write-back never races a read of the same offset
    a_ofs_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (owb_reg && req.ofs_rd) |-> (req.ofs_rd_addr != owb_addr_reg))
        else $error("offset read overlaps pending write-back");

    // element walk stays inside its bucket slice
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ELEM) |-> ((i_reg <= e_reg) && (e_reg <= br)))
        else $error("element walk past slice end");

    // an index error always carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_value_reg == '0))
        else $error("index error with nonzero value");

    // no write-back or result is pending during the clearing sweep
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!ewb_reg && !owb_reg && !out_valid_reg))
        else $error("activity during clearing sweep");

endmodule

`default_nettype wire

@@ rtl/core/range_add_point_query_buckets_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Range add / point query over bucketed 64-bit values.
// Channels (valid/ready, a word moves when both are high):
//   cmd : func (0 range add, 1 point query), first_index, end_index, addend.
//   res : value, index_error; one word per query, none for an add.
//   cfg : element_count write, always ready; write only while idle.
// Element values and bucket offsets live in two synchronous memories; each
// add is a read-modify-write walk driven by one sequencer.
// Throughput: one command at a time. An add walks the buckets up to the bucket
// holding the range end (offsets updated one per cycle, pipelined against the
// write-back), and walks the elements of each partly covered bucket one by one.
// A query scans buckets up to its own, reads its element and that bucket's
// offset, and loads their sum into the result register once it is free; an
// error query goes straight to the result register with a zero value.
// After reset a clearing sweep zeroes both memories, one entry per cycle across
// the larger store; cmd.ready stays low meanwhile.
// The result sits in an output register; a stalled receiver holds it while the
// next command is still accepted, and only a second query result waits.
module range_add_point_query_buckets_top
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rapq_cfg_if.sink   cfg,
    rapq_cmd_if.sink   cmd,
    rapq_res_if.source res
);
    import rapq_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [POS_W-1:0]   count_wide;
    logic [POS_W-1:0]   count_eff;
    mem_req_t           mem_req;
    mem_rsp_t           mem_rsp;

    // config register: always ready, latch on handshake
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(COUNT_RESET);
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.data;
        end
    end

    // clamp the element count to the store depth
    assign count_wide = POS_W'(count_reg);
    assign count_eff  = (count_wide > POS_W'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS)
                                                            : count_wide;

    rapq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .count (count_eff),
        .cmd   (cmd),
        .res   (res),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    rapq_store u_store
    (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

endmodule

`default_nettype wire
